[rtl/svpd_pkg.sv]
// ----------------------------------------------------------------------------
// svpd_pkg: shared types and constants of the servo steering mapper
// Word formats, register indexes, command codes, sequencer states and the
// widths of the serial arithmetic units.
// ----------------------------------------------------------------------------
package svpd_pkg;

   localparam int ANGLE_W    = 16;
   localparam int GAIN_W     = 16;
   localparam int GAIN_FRAC  = 8;
   localparam int SERVO_W    = 16;
   localparam int SPAN_W     = 15;
   localparam int MS_W       = 16;
   localparam int TERM_W     = 32;
   localparam int CMD_W      = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int MS_PER_S   = 1000;

   localparam int HIST_LEN   = 5;
   localparam int HIST_IDX_W = (HIST_LEN > 1) ? $clog2(HIST_LEN) : 1;
   localparam int FILL_W     = $clog2(HIST_LEN + 1);
   localparam int SUM_W      = ANGLE_W + FILL_W;

   localparam int SCALED_W   = ANGLE_W + GAIN_W - GAIN_FRAC + 1;
   localparam int DIFF_W     = SCALED_W + 1;
   localparam int KD_W       = GAIN_W + 10;
   localparam int TOTAL_W    = TERM_W + 1;

   localparam int MUL_A_W    = TOTAL_W - 1;
   localparam int MUL_B_W    = KD_W;
   localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
   localparam int MUL_CNT_W  = $clog2(MUL_B_W);

   localparam int DIV_NUM_W  = 51;
   localparam int DIV_DEN_W  = MS_W + GAIN_FRAC;
   localparam int DIV_CNT_W  = $clog2(DIV_NUM_W);

   localparam int VALUE_W    = DIV_NUM_W + 2;

   localparam logic [TERM_W-1:0] TERM_MAX = {1'b0, {(TERM_W-1){1'b1}}};
   localparam logic [TERM_W-1:0] TERM_MIN = {1'b1, {(TERM_W-1){1'b0}}};

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PROP_GAIN   = 3'd0,
      CSR_DERIV_GAIN  = 3'd1,
      CSR_CENTER      = 3'd2,
      CSR_LEFT_LIMIT  = 3'd3,
      CSR_RIGHT_LIMIT = 3'd4,
      CSR_LEFT_SPAN   = 3'd5,
      CSR_RIGHT_SPAN  = 3'd6
   } csr_index_type;

   typedef enum logic [CMD_W-1:0] {
      CMD_CORRECT = 2'd0,
      CMD_SET     = 2'd1,
      CMD_COMMIT  = 2'd2
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCALE,
      ST_SUM,
      ST_MEAN_GO,
      ST_MEAN_DIV,
      ST_DIFF,
      ST_DERIV,
      ST_TERM_DIV,
      ST_TOTAL,
      ST_MAP_SEL,
      ST_MAP_MUL,
      ST_MAP_DIV,
      ST_DONE
   } ctl_state_type;

   typedef struct packed {
      logic [CMD_W-1:0]          cmd;
      logic signed [ANGLE_W-1:0] target_angle;
      logic [MS_W-1:0]           elapsed_ms;
   } req_word_type;

   typedef struct packed {
      logic [SERVO_W-1:0]       servo_value;
      logic signed [TERM_W-1:0] correction_term;
   } rsp_word_type;

endpackage

[rtl/svpd_multiplier.sv]
// ----------------------------------------------------------------------------
// svpd_multiplier: unsigned shift-add multiplier
// Retires one multiplier bit per cycle; the product is valid when done
// pulses and holds until the next start.
// ----------------------------------------------------------------------------
module svpd_multiplier
   import svpd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [MUL_A_W-1:0] mcand,
   input  logic [MUL_B_W-1:0] mplr,
   output logic               done,
   output logic [MUL_P_W-1:0] product
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [MUL_CNT_W-1:0] cnt_ff, cnt_in;
   logic [MUL_A_W-1:0]   mcand_ff, mcand_in;
   logic [MUL_P_W-1:0]   prod_ff, prod_in;
   logic [MUL_A_W:0]     upper_sum;

   always_comb begin
      upper_sum = {1'b0, prod_ff[MUL_P_W-1:MUL_B_W]}
                + (prod_ff[0] ? {1'b0, mcand_ff} : '0);
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      mcand_in = mcand_ff;
      prod_in  = prod_ff;
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = MUL_CNT_W'(MUL_B_W - 1);
         mcand_in = mcand;
         prod_in  = {{MUL_A_W{1'b0}}, mplr};
      end else if (busy_ff) begin
         prod_in = {upper_sum, prod_ff[MUL_B_W-1:1]};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      mcand_ff <= mcand_in;
      prod_ff  <= prod_in;
   end

   assign done    = done_ff;
   assign product = prod_ff;

endmodule

[rtl/svpd_divider.sv]
// ----------------------------------------------------------------------------
// svpd_divider: unsigned restoring divider
// Produces one quotient bit per cycle; the quotient is valid when done
// pulses and holds until the next start. The divisor is never zero.
// ----------------------------------------------------------------------------
module svpd_divider
   import svpd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DIV_NUM_W-1:0] dividend,
   input  logic [DIV_DEN_W-1:0] divisor,
   output logic                 done,
   output logic [DIV_NUM_W-1:0] quotient
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_NUM_W-1:0] quot_ff, quot_in;
   logic [DIV_DEN_W:0]   trial;
   logic [DIV_DEN_W:0]   trial_sub;
   logic                 fits;

   always_comb begin
      trial     = {rem_ff, quot_ff[DIV_NUM_W-1]};
      trial_sub = trial - {1'b0, den_ff};
      fits      = trial >= {1'b0, den_ff};
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      den_in    = den_ff;
      rem_in    = rem_ff;
      quot_in   = quot_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(DIV_NUM_W - 1);
         den_in  = divisor;
         rem_in  = '0;
         quot_in = dividend;
      end else if (busy_ff) begin
         rem_in  = fits ? trial_sub[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
         quot_in = {quot_ff[DIV_NUM_W-2:0], fits};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

[rtl/servo_pd_steering_mapper_unit.sv]
// ----------------------------------------------------------------------------
// servo_pd_steering_mapper_unit: servo steering mapper with PD correction
// Keeps the steering target and a short history of it, and for each
// correction word computes the scaled target plus a derivative-like term,
// maps it onto the servo range and clamps it to the servo limits.
//
//   channel  direction  handshake            content
//   req      in         req_valid/req_ready  cmd, target_angle, elapsed_ms
//   rsp      out        rsp_valid/rsp_ready  servo_value, correction_term
//   csr      in         csr_wr_en            csr_index, csr_wdata
//
// A set or unused command word is taken and gives no result. A correction
// word runs the shift-add multiplier for the scale, derivative and mapping
// passes and the restoring divider for the mean, term and mapping passes,
// with the history summed between the scale and mean passes; both mapping
// passes are skipped when the total is zero. One word is in work at a time;
// req_ready is high only while the sequencer is idle. The result register
// frees the sequencer, which stalls only if a second result is due before
// the first has been taken. Reset is synchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
module servo_pd_steering_mapper_unit
   import svpd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_word_type          req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_word_type          rsp_word,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [GAIN_W-1:0]  prop_gain_ff;
   logic [GAIN_W-1:0]  deriv_gain_ff;
   logic [SERVO_W-1:0] center_ff;
   logic [SERVO_W-1:0] left_limit_ff;
   logic [SERVO_W-1:0] right_limit_ff;
   logic [SPAN_W-1:0]  left_span_ff;
   logic [SPAN_W-1:0]  right_span_ff;

   ctl_state_type state_ff, state_in;

   logic signed [ANGLE_W-1:0] pending_ff;
   logic signed [ANGLE_W-1:0] active_ff;
   logic signed [ANGLE_W-1:0] active_in;
   logic signed [ANGLE_W-1:0] hist_ff [HIST_LEN];
   logic [HIST_IDX_W-1:0]     hist_wr_ff;
   logic [FILL_W-1:0]         fill_ff;

   logic                       req_fire;
   logic                       is_correct;
   logic [ANGLE_W-1:0]         active_mag;
   logic                       tgt_neg_ff;
   logic [MS_W-1:0]            ms_ff;
   logic signed [SCALED_W-1:0] scaled_ff;
   logic signed [SCALED_W-1:0] scaled_in;
   logic [SCALED_W-2:0]        scaled_mag;
   logic signed [SUM_W-1:0]    sum_ff;
   logic [SUM_W-1:0]           sum_mag;
   logic [HIST_IDX_W-1:0]      sum_idx_ff;
   logic signed [SUM_W-1:0]    mean_ff;
   logic signed [DIFF_W-1:0]   diff;
   logic [DIFF_W-1:0]          diff_mag;
   logic                       diff_neg_ff;
   logic [KD_W-1:0]            kd_scaled;
   logic signed [TERM_W-1:0]   term_ff;
   logic [TERM_W-1:0]          term_in;
   logic signed [TOTAL_W-1:0]  total_ff;
   logic signed [TOTAL_W-1:0]  total_in;
   logic [TOTAL_W-1:0]         total_abs;
   logic                       total_zero;
   logic                       total_pos;
   logic signed [SERVO_W:0]    arm_diff;
   logic [SERVO_W:0]           arm_abs;
   logic                       prod_neg_ff;
   logic [SPAN_W-1:0]          span_ff;
   logic [SPAN_W-1:0]          span_in;
   logic signed [VALUE_W-1:0]  map_value;
   logic signed [VALUE_W-1:0]  center_value;
   logic [SERVO_W-1:0]         res_value_ff;

   logic                 mul_start;
   logic [MUL_A_W-1:0]   mul_mcand;
   logic [MUL_B_W-1:0]   mul_mplr;
   logic                 mul_done;
   logic [MUL_P_W-1:0]   mul_prod;
   logic                 div_start;
   logic [DIV_NUM_W-1:0] div_num;
   logic [DIV_DEN_W-1:0] div_den;
   logic                 div_done;
   logic [DIV_NUM_W-1:0] div_quot;

   logic         rsp_load;
   logic         rsp_valid_ff;
   rsp_word_type rsp_word_ff;

   function automatic logic [SERVO_W-1:0] servo_clamp(
      input logic signed [VALUE_W-1:0] value,
      input logic [SERVO_W-1:0]        upper,
      input logic [SERVO_W-1:0]        lower
   );
      logic signed [VALUE_W-1:0] upper_ext;
      logic signed [VALUE_W-1:0] lower_ext;
      logic [SERVO_W-1:0]        result;
      upper_ext = $signed({{(VALUE_W-SERVO_W){1'b0}}, upper});
      lower_ext = $signed({{(VALUE_W-SERVO_W){1'b0}}, lower});
      if (value > upper_ext) begin
         result = (upper < lower) ? lower : upper;
      end else if (value < lower_ext) begin
         result = lower;
      end else begin
         result = value[SERVO_W-1:0];
      end
      return result;
   endfunction

   svpd_multiplier u_multiplier (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (mul_mcand),
      .mplr    (mul_mplr),
      .done    (mul_done),
      .product (mul_prod)
   );

   svpd_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      unique case (req_word.cmd) inside
         CMD_CORRECT, CMD_COMMIT: is_correct = 1'b1;
         default:                 is_correct = 1'b0;
      endcase
   end

   always_comb begin
      active_in  = (req_word.cmd == CMD_COMMIT) ? req_word.target_angle : active_ff;
      active_mag = active_in[ANGLE_W-1] ? ANGLE_W'(-active_in) : ANGLE_W'(active_in);

      scaled_mag = mul_prod[ANGLE_W+GAIN_W-1:GAIN_FRAC];
      scaled_in  = tgt_neg_ff ? -$signed({1'b0, scaled_mag}) : $signed({1'b0, scaled_mag});

      sum_mag  = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);

      diff      = DIFF_W'(scaled_ff) - DIFF_W'(mean_ff);
      diff_mag  = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
      kd_scaled = KD_W'(deriv_gain_ff) * KD_W'(MS_PER_S);

      if (!diff_neg_ff) begin
         term_in = (|div_quot[DIV_NUM_W-1:TERM_W-1]) ? TERM_MAX : div_quot[TERM_W-1:0];
      end else if ((|div_quot[DIV_NUM_W-1:TERM_W])
                   || (div_quot[TERM_W-1] && (|div_quot[TERM_W-2:0]))) begin
         term_in = TERM_MIN;
      end else begin
         term_in = -div_quot[TERM_W-1:0];
      end

      total_in   = TOTAL_W'(scaled_ff) + TOTAL_W'(term_ff);
      total_abs  = total_ff[TOTAL_W-1] ? TOTAL_W'(-total_ff) : TOTAL_W'(total_ff);
      total_zero = (total_ff == '0);
      total_pos  = !total_ff[TOTAL_W-1] && !total_zero;

      if (total_pos) begin
         arm_diff = $signed({1'b0, center_ff}) - $signed({1'b0, right_limit_ff});
         span_in  = (right_span_ff == '0) ? SPAN_W'(1) : right_span_ff;
      end else begin
         arm_diff = $signed({1'b0, left_limit_ff}) - $signed({1'b0, center_ff});
         span_in  = (left_span_ff == '0) ? SPAN_W'(1) : left_span_ff;
      end
      arm_abs = arm_diff[SERVO_W] ? (SERVO_W+1)'(-arm_diff) : (SERVO_W+1)'(arm_diff);

      center_value = $signed({{(VALUE_W-SERVO_W){1'b0}}, center_ff});
      if (prod_neg_ff) begin
         map_value = center_value + $signed({2'b00, div_quot});
      end else begin
         map_value = center_value - $signed({2'b00, div_quot});
      end
   end

   always_comb begin
      state_in  = state_ff;
      mul_start = 1'b0;
      mul_mcand = '0;
      mul_mplr  = '0;
      div_start = 1'b0;
      div_num   = '0;
      div_den   = '0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && is_correct) begin
               mul_start = 1'b1;
               mul_mcand = MUL_A_W'(active_mag);
               mul_mplr  = MUL_B_W'(prop_gain_ff);
               state_in  = ST_SCALE;
            end
         end
         ST_SCALE: begin
            if (mul_done) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            if (sum_idx_ff == HIST_IDX_W'(HIST_LEN - 1)) begin
               state_in = ST_MEAN_GO;
            end
         end
         ST_MEAN_GO: begin
            div_start = 1'b1;
            div_num   = DIV_NUM_W'(sum_mag);
            div_den   = DIV_DEN_W'(fill_ff);
            state_in  = ST_MEAN_DIV;
         end
         ST_MEAN_DIV: begin
            if (div_done) begin
               state_in = ST_DIFF;
            end
         end
         ST_DIFF: begin
            mul_start = 1'b1;
            mul_mcand = MUL_A_W'(diff_mag);
            mul_mplr  = MUL_B_W'(kd_scaled);
            state_in  = ST_DERIV;
         end
         ST_DERIV: begin
            if (mul_done) begin
               div_start = 1'b1;
               div_num   = mul_prod[DIV_NUM_W-1:0];
               div_den   = {ms_ff, {GAIN_FRAC{1'b0}}};
               state_in  = ST_TERM_DIV;
            end
         end
         ST_TERM_DIV: begin
            if (div_done) begin
               state_in = ST_TOTAL;
            end
         end
         ST_TOTAL: begin
            state_in = ST_MAP_SEL;
         end
         ST_MAP_SEL: begin
            if (total_zero) begin
               state_in = ST_DONE;
            end else begin
               mul_start = 1'b1;
               mul_mcand = total_abs[MUL_A_W-1:0];
               mul_mplr  = MUL_B_W'(arm_abs[SERVO_W-1:0]);
               state_in  = ST_MAP_MUL;
            end
         end
         ST_MAP_MUL: begin
            if (mul_done) begin
               div_start = 1'b1;
               div_num   = mul_prod[DIV_NUM_W-1:0];
               div_den   = DIV_DEN_W'(span_ff);
               state_in  = ST_MAP_DIV;
            end
         end
         ST_MAP_DIV: begin
            if (div_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         pending_ff   <= '0;
         active_ff    <= '0;
         hist_wr_ff   <= '0;
         fill_ff      <= '0;
      end else begin
         state_ff <= state_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (req_fire) begin
            if ((req_word.cmd == CMD_SET) || (req_word.cmd == CMD_COMMIT)) begin
               pending_ff <= req_word.target_angle;
            end
            if (is_correct) begin
               active_ff  <= active_in;
               hist_wr_ff <= (hist_wr_ff == HIST_IDX_W'(HIST_LEN - 1)) ? '0
                                                                      : hist_wr_ff + 1'b1;
               if (fill_ff != FILL_W'(HIST_LEN)) begin
                  fill_ff <= fill_ff + 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff   <= GAIN_W'(256);
         deriv_gain_ff  <= '0;
         center_ff      <= SERVO_W'(32768);
         left_limit_ff  <= '1;
         right_limit_ff <= '0;
         left_span_ff   <= SPAN_W'(900);
         right_span_ff  <= SPAN_W'(900);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_PROP_GAIN:   prop_gain_ff   <= csr_wdata[GAIN_W-1:0];
            CSR_DERIV_GAIN:  deriv_gain_ff  <= csr_wdata[GAIN_W-1:0];
            CSR_CENTER:      center_ff      <= csr_wdata[SERVO_W-1:0];
            CSR_LEFT_LIMIT:  left_limit_ff  <= csr_wdata[SERVO_W-1:0];
            CSR_RIGHT_LIMIT: right_limit_ff <= csr_wdata[SERVO_W-1:0];
            CSR_LEFT_SPAN:   left_span_ff   <= csr_wdata[SPAN_W-1:0];
            CSR_RIGHT_SPAN:  right_span_ff  <= csr_wdata[SPAN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // The history store has no reset; only the entries below the fill count are summed.
   always_ff @(posedge clock) begin
      if (req_fire && is_correct) begin
         hist_ff[hist_wr_ff] <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && is_correct) begin
               tgt_neg_ff <= active_in[ANGLE_W-1];
               ms_ff      <= (req_word.elapsed_ms == '0) ? MS_W'(1) : req_word.elapsed_ms;
            end
         end
         ST_SCALE: begin
            if (mul_done) begin
               scaled_ff  <= scaled_in;
               sum_ff     <= '0;
               sum_idx_ff <= '0;
            end
         end
         ST_SUM: begin
            if (FILL_W'(sum_idx_ff) < fill_ff) begin
               sum_ff <= sum_ff + SUM_W'(hist_ff[sum_idx_ff]);
            end
            if (sum_idx_ff != HIST_IDX_W'(HIST_LEN - 1)) begin
               sum_idx_ff <= sum_idx_ff + 1'b1;
            end
         end
         ST_MEAN_DIV: begin
            if (div_done) begin
               mean_ff <= sum_ff[SUM_W-1] ? -$signed(div_quot[SUM_W-1:0])
                                          : $signed(div_quot[SUM_W-1:0]);
            end
         end
         ST_DIFF: begin
            diff_neg_ff <= diff[DIFF_W-1];
         end
         ST_TERM_DIV: begin
            if (div_done) begin
               term_ff <= $signed(term_in);
            end
         end
         ST_TOTAL: begin
            total_ff <= total_in;
         end
         ST_MAP_SEL: begin
            prod_neg_ff <= arm_diff[SERVO_W] ^ total_ff[TOTAL_W-1];
            span_ff     <= span_in;
            if (total_zero) begin
               res_value_ff <= servo_clamp(center_value, left_limit_ff, right_limit_ff);
            end
         end
         ST_MAP_DIV: begin
            if (div_done) begin
               res_value_ff <= servo_clamp(map_value, left_limit_ff, right_limit_ff);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_word_ff.servo_value     <= res_value_ff;
         rsp_word_ff.correction_term <= term_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

[test/tb_servo_pd_steering_mapper_unit.sv]
// ----------------------------------------------------------------------------
// tb_servo_pd_steering_mapper_unit: regression bench for the steering mapper
// Drives command words through the request channel and checks every result
// word against a cycle-free software copy of the mapper that tracks the
// pending and committed targets, the target history and all registers.
// Directed words cover the field extremes, every command, zero elapsed time,
// zero spans, crossed servo limits and saturation of the correction term;
// random phases then sweep several register settings, with random idling in all phases but every fourth.
// ----------------------------------------------------------------------------
module tb_servo_pd_steering_mapper_unit;
   import svpd_pkg::*;

   localparam int HALF_PERIOD   = 5;
   localparam int SETTLE_CYCLES = 300;
   localparam int CYCLE_LIMIT   = 2000000;
   localparam int PHASES        = 8;
   localparam int PHASE_WORDS   = 160;

   localparam logic [CMD_W-1:0]     CMD_UNUSED     = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_NO_REG     = 3'd7;
   localparam longint               GAIN_ONE       = longint'(1) << GAIN_FRAC;
   localparam longint               TERM_HI        = longint'(TERM_MAX);
   localparam longint               TERM_LO        = -TERM_HI - 1;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_word_type          req_word = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_word_type          rsp_word;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Software copy of the registers and the steering state.
   logic [GAIN_W-1:0]         gain_p = 16'd256;
   logic [GAIN_W-1:0]         gain_d = 16'd0;
   logic [SERVO_W-1:0]        servo_mid = 16'd32768;
   logic [SERVO_W-1:0]        servo_hi = 16'd65535;
   logic [SERVO_W-1:0]        servo_lo = 16'd0;
   logic [SPAN_W-1:0]         span_left = 15'd900;
   logic [SPAN_W-1:0]         span_right = 15'd900;
   logic signed [ANGLE_W-1:0] pend_angle = '0;
   logic                      commit_due = 1'b0;
   logic signed [ANGLE_W-1:0] active_angle = '0;
   longint                    angle_hist [HIST_LEN];
   int                        hist_fill = 0;
   int                        hist_wr = 0;

   rsp_word_type servo_expect_q [$];
   rsp_word_type due_word;
   int           errors = 0;
   int           cycle_count = 0;
   int           rsp_hold = 0;
   bit           idling_on = 1'b1;

   servo_pd_steering_mapper_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #(HALF_PERIOD) clock = ~clock;

   function automatic int idle_gap();
      int r;
      if (!idling_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 4);
      return $urandom_range(10, 40);
   endfunction

   function automatic req_word_type request(input logic [CMD_W-1:0] c,
                                            input logic signed [ANGLE_W-1:0] a,
                                            input logic [MS_W-1:0] m);
      req_word_type w;
      w.cmd = c;
      w.target_angle = a;
      w.elapsed_ms = m;
      return w;
   endfunction

   task automatic predict_steering(input req_word_type w);
      longint       sum, mean, scaled, term, total, value, span, ms;
      int           i;
      rsp_word_type e;
      if (w.cmd == CMD_UNUSED) return;
      if (w.cmd == CMD_SET) begin
         pend_angle = w.target_angle;
         return;
      end
      if (w.cmd == CMD_COMMIT) begin
         pend_angle = w.target_angle;
         commit_due = 1'b1;
      end
      ms = (w.elapsed_ms == '0) ? 1 : longint'(w.elapsed_ms);
      if (commit_due) begin
         active_angle = pend_angle;
         commit_due = 1'b0;
      end
      angle_hist[hist_wr] = longint'(active_angle);
      hist_wr = (hist_wr + 1) % HIST_LEN;
      if (hist_fill < HIST_LEN) hist_fill++;
      sum = 0;
      for (i = 0; i < hist_fill; i++) sum += angle_hist[i];
      mean = sum / hist_fill;
      scaled = longint'(active_angle) * longint'(gain_p) / GAIN_ONE;
      term = (scaled - mean) * MS_PER_S * longint'(gain_d) / (GAIN_ONE * ms);
      if (term > TERM_HI) term = TERM_HI;
      else if (term < TERM_LO) term = TERM_LO;
      total = scaled + term;
      value = longint'(servo_mid);
      if (total > 0) begin
         span = (span_right == '0) ? 1 : longint'(span_right);
         value = longint'(servo_mid)
                 - (longint'(servo_mid) - longint'(servo_lo)) * total / span;
      end else if (total < 0) begin
         span = (span_left == '0) ? 1 : longint'(span_left);
         value = longint'(servo_mid)
                 - (longint'(servo_hi) - longint'(servo_mid)) * total / span;
      end
      if (value > longint'(servo_hi)) value = longint'(servo_hi);
      if (value < longint'(servo_lo)) value = longint'(servo_lo);
      e.servo_value = value[SERVO_W-1:0];
      e.correction_term = term[TERM_W-1:0];
      servo_expect_q.insert(servo_expect_q.size(), e);
   endtask

   task automatic send_word(input req_word_type w);
      int gap;
      @(negedge clock);
      req_valid <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (!req_ready);
      predict_steering(w);
      gap = idle_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (servo_expect_q.size() != 0) @(posedge clock);
   endtask

   task automatic settle_block();
      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_PROP_GAIN:   gain_p = data;
         CSR_DERIV_GAIN:  gain_d = data;
         CSR_CENTER:      servo_mid = data;
         CSR_LEFT_LIMIT:  servo_hi = data;
         CSR_RIGHT_LIMIT: servo_lo = data;
         CSR_LEFT_SPAN:   span_left = data[SPAN_W-1:0];
         CSR_RIGHT_SPAN:  span_right = data[SPAN_W-1:0];
         default: ;
      endcase
   endtask

   task automatic write_all(input logic [CSR_DATA_W-1:0] kp, input logic [CSR_DATA_W-1:0] kd,
                            input logic [CSR_DATA_W-1:0] mid, input logic [CSR_DATA_W-1:0] hi,
                            input logic [CSR_DATA_W-1:0] lo, input logic [CSR_DATA_W-1:0] ls,
                            input logic [CSR_DATA_W-1:0] rs);
      write_reg(CSR_PROP_GAIN, kp);
      write_reg(CSR_DERIV_GAIN, kd);
      write_reg(CSR_CENTER, mid);
      write_reg(CSR_LEFT_LIMIT, hi);
      write_reg(CSR_RIGHT_LIMIT, lo);
      write_reg(CSR_LEFT_SPAN, ls);
      write_reg(CSR_RIGHT_SPAN, rs);
   endtask

   function automatic req_word_type random_request();
      req_word_type w;
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) w.cmd = CMD_COMMIT;
      else if (r < 75) w.cmd = CMD_CORRECT;
      else if (r < 95) w.cmd = CMD_SET;
      else w.cmd = CMD_UNUSED;
      r = $urandom_range(0, 9);
      if (r < 5) w.target_angle = 16'($urandom_range(0, 2400)) - 16'd1200;
      else if (r < 7) w.target_angle = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      else w.target_angle = 16'($urandom());
      r = $urandom_range(0, 9);
      if (r == 0) w.elapsed_ms = '0;
      else if (r < 6) w.elapsed_ms = 16'($urandom_range(1, 50));
      else w.elapsed_ms = 16'($urandom());
      return w;
   endfunction

   task automatic load_settings(input int phase);
      logic [CSR_DATA_W-1:0] mid;
      case (phase)
         0: write_all(16'd256, 16'd0, 16'd32768, 16'd65535, 16'd0, 16'd900, 16'd900);
         1: write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
         2: write_all(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
         default: begin
            mid = 16'($urandom());
            write_reg(CSR_PROP_GAIN, ($urandom_range(0, 3) == 0) ?
                      16'($urandom()) : 16'($urandom_range(64, 1024)));
            write_reg(CSR_DERIV_GAIN, ($urandom_range(0, 3) == 0) ?
                      16'($urandom()) : 16'($urandom_range(0, 64)));
            write_reg(CSR_CENTER, mid);
            write_reg(CSR_LEFT_LIMIT, ($urandom_range(0, 7) == 0) ?
                      16'($urandom()) : 16'($urandom_range(mid, 65535)));
            write_reg(CSR_RIGHT_LIMIT, ($urandom_range(0, 7) == 0) ?
                      16'($urandom()) : 16'($urandom_range(0, mid)));
            write_reg(CSR_LEFT_SPAN, ($urandom_range(0, 3) == 0) ?
                      16'($urandom()) : 16'($urandom_range(1, 2000)));
            write_reg(CSR_RIGHT_SPAN, ($urandom_range(0, 3) == 0) ?
                      16'($urandom()) : 16'($urandom_range(1, 2000)));
         end
      endcase
   endtask

   task automatic test_reset_defaults();
      send_word(request(CMD_CORRECT, 16'sd0, 16'd0));
      send_word(request(CMD_COMMIT, 16'sd900, 16'd20));
      send_word(request(CMD_COMMIT, -16'sd900, 16'd65535));
   endtask

   task automatic test_command_handling();
      send_word(request(CMD_SET, 16'sd450, 16'd7));
      send_word(request(CMD_CORRECT, 16'sd0, 16'd1));
      send_word(request(CMD_UNUSED, 16'sh7FFF, 16'hFFFF));
      send_word(request(CMD_COMMIT, 16'sh7FFF, 16'd100));
      send_word(request(CMD_COMMIT, 16'sh8000, 16'd100));
      send_word(request(CMD_SET, 16'sd123, 16'd0));
      send_word(request(CMD_CORRECT, 16'sd0, 16'd3));
      send_word(request(CMD_CORRECT, -16'sd1, 16'hAAAA));
   endtask

   task automatic test_derivative_saturation();
      settle_block();
      write_reg(CSR_PROP_GAIN, 16'hFFFF);
      write_reg(CSR_DERIV_GAIN, 16'hFFFF);
      send_word(request(CMD_COMMIT, 16'sh8000, 16'd0));
      send_word(request(CMD_COMMIT, 16'sh7FFF, 16'd0));
      send_word(request(CMD_CORRECT, 16'sd0, 16'hFFFF));
      send_word(request(CMD_COMMIT, 16'sd0, 16'd1));
   endtask

   task automatic test_span_and_limits();
      settle_block();
      write_all(16'd256, 16'd0, 16'd150, 16'd100, 16'd200, 16'd0, 16'h8000);
      write_reg(CSR_NO_REG, 16'hFFFF);
      send_word(request(CMD_COMMIT, 16'sd1, 16'd5));
      send_word(request(CMD_COMMIT, -16'sd1, 16'd5));
      send_word(request(CMD_COMMIT, 16'sd0, 16'd0));
      settle_block();
      write_all(16'd256, 16'd0, 16'd32768, 16'd40000, 16'd20000, 16'd0, 16'd0);
      send_word(request(CMD_COMMIT, 16'sd2, 16'd9));
      send_word(request(CMD_COMMIT, -16'sd2, 16'd9));
   endtask

   task automatic test_random_traffic();
      int phase, n;
      for (phase = 0; phase < PHASES; phase++) begin
         settle_block();
         load_settings(phase);
         idling_on = (phase % 4) != 3;
         for (n = 0; n < PHASE_WORDS; n++) begin
            if (n == PHASE_WORDS / 2) wait_for_results();
            send_word(random_request());
         end
      end
      idling_on = 1'b1;
   endtask

   always @(negedge clock) begin
      if (rsp_hold != 0) begin
         rsp_ready <= 1'b0;
         rsp_hold = rsp_hold - 1;
      end else begin
         rsp_ready <= 1'b1;
         if ($urandom_range(0, 2) == 0) rsp_hold = idle_gap();
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (servo_expect_q.size() == 0) begin
            $display("%0t: unexpected word, servo_value %0d correction_term %0d",
                     $time, rsp_word.servo_value, rsp_word.correction_term);
            errors++;
         end else begin
            due_word = servo_expect_q.pop_front();
            if (rsp_word.servo_value !== due_word.servo_value) begin
               $display("%0t: servo_value expected %0d actual %0d",
                        $time, due_word.servo_value, rsp_word.servo_value);
               errors++;
            end
            if (rsp_word.correction_term !== due_word.correction_term) begin
               $display("%0t: correction_term expected %0d actual %0d",
                        $time, due_word.correction_term, rsp_word.correction_term);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("servo_pd_steering_mapper_unit regression: fail");
         $finish;
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_command_handling();
      test_derivative_saturation();
      test_span_and_limits();
      test_random_traffic();
      settle_block();
      if (errors == 0) begin
         $display("servo_pd_steering_mapper_unit regression: pass");
      end else begin
         $display("servo_pd_steering_mapper_unit regression: fail");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/svpd_pkg.sv
rtl/svpd_multiplier.sv
rtl/svpd_divider.sv
rtl/servo_pd_steering_mapper_unit.sv
test/tb_servo_pd_steering_mapper_unit.sv
